FILE: src/ste_pkg.sv
// shared types and constants for the space-run entab unit
package ste_pkg;

   // field widths
   localparam int TW_W  = 7;
   localparam int REP_W = 13;
   localparam int OP_W  = 3;

   // item kinds
   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // characters of interest
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // reset value of the tab width register
   localparam logic [TW_W-1:0] TAB_WIDTH_RESET = 7'd4;

   // command codes from the front to the back
   localparam logic [OP_W-1:0] OP_SPACE = 3'd0;
   localparam logic [OP_W-1:0] OP_TAB   = 3'd1;
   localparam logic [OP_W-1:0] OP_EOL   = 3'd2;
   localparam logic [OP_W-1:0] OP_TEXT  = 3'd3;
   localparam logic [OP_W-1:0] OP_END   = 3'd4;

   // classified item waiting for the back
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [7:0]      data;
   } cmd_type;

   // one run-length result
   typedef struct packed {
      logic [7:0]       out_byte;
      logic [REP_W-1:0] repeat_res;
      logic             last;
   } res_type;

endpackage

FILE: src/space_run_to_tab_entab_unit.sv
// top level of the space-run entab unit
//
// Rewrites runs of spaces and tabs in a text byte stream as tabs to each
// crossed tab stop followed by the remaining spaces; a one-column run ending
// in a space stays one space. Each item gives up to three run-length results
// (tab count, space count, then the byte), the last one flagged. CR and LF
// flush the run, pass through and restart the column; an end item flushes a
// trailing run. The front queues two items; the back handles one at a time.
// A space is taken by the back directly. A tab, and any byte that closes a
// pending run other than a single space, go through a bit-serial divider of
// CW = clog2(MAX_COLUMNS+1) steps; a byte with no pending run goes straight
// to emission. Tab width is written through csr_wen/csr_wdata; the user
// must write it only while the unit is idle; the unit does not enforce it.
module space_run_to_tab_entab_unit #(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   // item input
   input  logic                      push,
   output logic                      full,
   input  logic                      req_kind,
   input  logic [7:0]                req_in_byte,
   // results
   output logic                      empty,
   input  logic                      pop,
   output logic [7:0]                rsp_out_byte,
   output logic [ste_pkg::REP_W-1:0] rsp_repeat_res,
   output logic                      rsp_last,
   // tab width register
   input  logic                      csr_wen,
   input  logic [ste_pkg::TW_W-1:0]  csr_wdata
);

   logic             cmd_valid;
   logic             cmd_pop;
   ste_pkg::cmd_type cmd;
   ste_pkg::res_type rsp;

   // classify and queue
   ste_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_kind    (req_kind),
      .req_in_byte (req_in_byte),
      .cmd_pop     (cmd_pop),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd)
   );

   // execute and emit
   ste_back #(
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp),
      .empty     (empty),
      .pop       (pop)
   );

   assign rsp_out_byte   = rsp.out_byte;
   assign rsp_repeat_res = rsp.repeat_res;
   assign rsp_last       = rsp.last;

endmodule

FILE: src/ste_fifo.sv
// two-entry register queue used between the stages and at the result side
module ste_fifo #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] wdata,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] rdata,
   output logic         empty
);

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [W-1:0]     mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   // handshake decode
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = push & ~full;
   assign do_rd = pop & ~empty;
   assign rdata = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: src/ste_div.sv
// two-lane restoring divider, one quotient bit per lane per cycle, shared divisor
module ste_div #(
   parameter int DW = 13
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ste_pkg::TW_W-1:0] dvs,
   input  logic [DW-1:0]            dvd_a,
   input  logic [DW-1:0]            dvd_b,
   output logic [DW-1:0]            quo_a,
   output logic [ste_pkg::TW_W-1:0] rem_a,
   output logic [DW-1:0]            quo_b,
   output logic                     done
);

   localparam int TW_W  = ste_pkg::TW_W;
   localparam int CNT_W = $clog2(DW + 1);
   localparam int LANES = 2;

   logic [DW-1:0]    q_ff   [LANES];
   logic [DW-1:0]    q_in   [LANES];
   logic [TW_W-1:0]  rem_ff [LANES];
   logic [TW_W-1:0]  rem_in [LANES];
   logic [TW_W:0]    trial  [LANES];
   logic [TW_W:0]    diff   [LANES];
   logic             ge     [LANES];
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   // one shift-compare-subtract step per lane
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         trial[l]  = {rem_ff[l], q_ff[l][DW-1]};
         ge[l]     = (trial[l] >= {1'b0, dvs});
         diff[l]   = trial[l] - {1'b0, dvs};
         rem_in[l] = ge[l] ? diff[l][TW_W-1:0] : trial[l][TW_W-1:0];
         q_in[l]   = {q_ff[l][DW-2:0], ge[l]};
      end
   end

   // step counter and completion pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff  <= CNT_W'(DW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // quotient and remainder shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff[0]   <= dvd_a;
         q_ff[1]   <= dvd_b;
         rem_ff[0] <= '0;
         rem_ff[1] <= '0;
      end else if (busy_ff) begin
         for (int l = 0; l < LANES; l++) begin
            q_ff[l]   <= q_in[l];
            rem_ff[l] <= rem_in[l];
         end
      end
   end

   assign quo_a = q_ff[0];
   assign rem_a = rem_ff[0];
   assign quo_b = q_ff[1];
   assign done  = done_ff;

endmodule

FILE: src/ste_front.sv
// front end: takes items, sorts them into commands and queues them for the back
module ste_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic             req_kind,
   input  logic [7:0]       req_in_byte,
   input  logic             cmd_pop,
   output logic             cmd_valid,
   output ste_pkg::cmd_type cmd
);

   localparam int CMD_W = $bits(ste_pkg::cmd_type);

   ste_pkg::cmd_type cls;
   logic [CMD_W-1:0] cmd_vec;
   logic             cmd_empty;

   // classify the incoming item
   always_comb begin
      cls.data = req_in_byte;
      priority if (req_kind == ste_pkg::KIND_END) begin
         cls.op = ste_pkg::OP_END;
      end else if (req_in_byte == ste_pkg::CH_SPACE) begin
         cls.op = ste_pkg::OP_SPACE;
      end else if (req_in_byte == ste_pkg::CH_TAB) begin
         cls.op = ste_pkg::OP_TAB;
      end else if (req_in_byte == ste_pkg::CH_CR || req_in_byte == ste_pkg::CH_LF) begin
         cls.op = ste_pkg::OP_EOL;
      end else begin
         cls.op = ste_pkg::OP_TEXT;
      end
   end

   // command queue towards the back
   ste_fifo #(
      .W(CMD_W)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (cls),
      .full  (full),
      .pop   (cmd_pop),
      .rdata (cmd_vec),
      .empty (cmd_empty)
   );

   assign cmd_valid = ~cmd_empty;
   assign cmd       = ste_pkg::cmd_type'(cmd_vec);

endmodule

FILE: src/ste_back.sv
// back end: column tracking, run flushing through the divider, result emission
module ste_back #(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic [ste_pkg::TW_W-1:0] csr_wdata,
   input  logic                     cmd_valid,
   input  ste_pkg::cmd_type         cmd,
   output logic                     cmd_pop,
   output ste_pkg::res_type         rsp,
   output logic                     empty,
   input  logic                     pop
);

   localparam int CW    = $clog2(MAX_COLUMNS + 1);
   localparam int SW    = CW + 1;
   localparam int REP_W = ste_pkg::REP_W;
   localparam int TW_W  = ste_pkg::TW_W;
   localparam int RW    = (CW > REP_W) ? CW : REP_W;
   localparam int RES_W = $bits(ste_pkg::res_type);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CW-1:0]    column_ff, column_in;
   logic [CW-1:0]    run_start_ff, run_start_in;
   logic             in_run_ff, in_run_in;
   logic             prev_space_ff, prev_space_in;
   logic [REP_W-1:0] tabs_ff, tabs_in;
   logic [REP_W-1:0] spaces_ff, spaces_in;
   logic             byte_sent_ff, byte_sent_in;
   logic [TW_W-1:0]  tab_width_ff, tab_width_in;

   logic [TW_W-1:0]  tw;
   logic [CW-1:0]    run_w;
   logic             single;
   logic [CW-1:0]    quo_a, quo_b;
   logic [TW_W-1:0]  rem_a;
   logic             div_start, div_done;
   logic [CW-1:0]    tabs_c, spaces_c;
   logic [SW-1:0]    tab_sum, one_sum;
   logic             out_push, out_full;
   ste_pkg::res_type out_data;
   logic [RES_W-1:0] rsp_vec;

   // clamp a grown column to the bound
   function automatic logic [CW-1:0] sat(input logic [SW-1:0] s);
      sat = (s > SW'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : s[CW-1:0];
   endfunction

   // keep the low bits of a count for the repeat field
   function automatic logic [REP_W-1:0] to_rep(input logic [CW-1:0] v);
      logic [RW-1:0] w;
      w      = RW'(v);
      to_rep = w[REP_W-1:0];
   endfunction

   // quotients of column and run start, and remainder of column, by the tab width
   ste_div #(
      .DW(CW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .dvs   (tw),
      .dvd_a (column_ff),
      .dvd_b (run_start_ff),
      .quo_a (quo_a),
      .rem_a (rem_a),
      .quo_b (quo_b),
      .done  (div_done)
   );

   // run arithmetic
   always_comb begin
      tw       = (tab_width_ff == '0) ? TW_W'(1) : tab_width_ff;
      run_w    = column_ff - run_start_ff;
      single   = in_run_ff && prev_space_ff && (run_w == CW'(1));
      tabs_c   = quo_a - quo_b;
      spaces_c = (tabs_c != '0) ? CW'(rem_a) : run_w;
      tab_sum  = {1'b0, column_ff} + SW'(tw - rem_a);
      one_sum  = {1'b0, column_ff} + SW'(1);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      column_in     = column_ff;
      run_start_in  = run_start_ff;
      in_run_in     = in_run_ff;
      prev_space_in = prev_space_ff;
      tabs_in       = tabs_ff;
      spaces_in     = spaces_ff;
      byte_sent_in  = byte_sent_ff;
      tab_width_in  = csr_wen ? csr_wdata : tab_width_ff;
      cmd_pop       = 1'b0;
      div_start     = 1'b0;
      out_push      = 1'b0;
      out_data      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  ste_pkg::OP_SPACE: begin
                     if (!in_run_ff) begin
                        run_start_in = column_ff;
                     end
                     in_run_in     = 1'b1;
                     column_in     = sat(one_sum);
                     prev_space_in = 1'b1;
                     cmd_pop       = 1'b1;
                  end
                  ste_pkg::OP_TAB: begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
                  default: begin
                     // line end, text byte or end item: flush then emit
                     byte_sent_in = 1'b0;
                     if (in_run_ff && !single) begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end else begin
                        tabs_in   = '0;
                        spaces_in = single ? REP_W'(1) : '0;
                        state_in  = S_EMIT;
                     end
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (cmd.op == ste_pkg::OP_TAB) begin
                  if (!in_run_ff) begin
                     run_start_in = column_ff;
                  end
                  in_run_in     = 1'b1;
                  prev_space_in = 1'b0;
                  column_in     = sat(tab_sum);
                  cmd_pop       = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  tabs_in   = to_rep(tabs_c);
                  spaces_in = to_rep(spaces_c);
                  state_in  = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            // tabs, then spaces, then the byte itself (none for an end item)
            priority if (tabs_ff != '0) begin
               out_push            = 1'b1;
               out_data.out_byte   = ste_pkg::CH_TAB;
               out_data.repeat_res = tabs_ff;
               out_data.last       = (spaces_ff == '0) && (cmd.op == ste_pkg::OP_END);
               if (!out_full) begin
                  tabs_in = '0;
               end
            end else if (spaces_ff != '0) begin
               out_push            = 1'b1;
               out_data.out_byte   = ste_pkg::CH_SPACE;
               out_data.repeat_res = spaces_ff;
               out_data.last       = (cmd.op == ste_pkg::OP_END);
               if (!out_full) begin
                  spaces_in = '0;
               end
            end else if (cmd.op != ste_pkg::OP_END && !byte_sent_ff) begin
               out_push            = 1'b1;
               out_data.out_byte   = cmd.data;
               out_data.repeat_res = REP_W'(1);
               out_data.last       = 1'b1;
               if (!out_full) begin
                  byte_sent_in = 1'b1;
               end
            end else begin
               in_run_in     = 1'b0;
               prev_space_in = 1'b0;
               if (cmd.op == ste_pkg::OP_TEXT) begin
                  column_in = sat(one_sum);
               end else begin
                  column_in    = '0;
                  run_start_in = '0;
               end
               cmd_pop  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         column_ff     <= '0;
         run_start_ff  <= '0;
         in_run_ff     <= 1'b0;
         prev_space_ff <= 1'b0;
         tabs_ff       <= '0;
         spaces_ff     <= '0;
         byte_sent_ff  <= 1'b0;
         tab_width_ff  <= ste_pkg::TAB_WIDTH_RESET;
      end else begin
         state_ff      <= state_in;
         column_ff     <= column_in;
         run_start_ff  <= run_start_in;
         in_run_ff     <= in_run_in;
         prev_space_ff <= prev_space_in;
         tabs_ff       <= tabs_in;
         spaces_ff     <= spaces_in;
         byte_sent_ff  <= byte_sent_in;
         tab_width_ff  <= tab_width_in;
      end
   end

   // result queue
   ste_fifo #(
      .W(RES_W)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (pop),
      .rdata (rsp_vec),
      .empty (empty)
   );

   assign rsp = ste_pkg::res_type'(rsp_vec);

endmodule
